// ===== rtl/core/jssc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jssc_pkg
// shared types, constants and speed curve table of the joystick stepper
// speed controller
// ----------------------------------------------------------------------------
package jssc_pkg;

    // table and filter sizing
    localparam int CURVE_ENTRIES        = 129;
    localparam int FILTER_FRACTION_BITS = 16;
    localparam int ROM_ENTRIES          = 129;
    localparam int ROM_LAST             = ROM_ENTRIES - 1;
    localparam int CURVE_LAST           = (CURVE_ENTRIES - 1 > ROM_LAST) ?
                                          ROM_LAST : CURVE_ENTRIES - 1;
    localparam int CURVE_IDX_W          = (CURVE_LAST < 1) ? 1 : $clog2(CURVE_LAST + 1);

    // fixed point widths
    localparam int ALPHA_BITS = 16;
    localparam int OFFSET_W   = 9;
    localparam int ACC_W      = OFFSET_W + FILTER_FRACTION_BITS;
    localparam int PRODA_W    = ALPHA_BITS + 1 + OFFSET_W;
    localparam int PRODB_W    = ALPHA_BITS + 2 + ACC_W;
    localparam int SUM_W      = PRODB_W + 1;
    localparam int PERIOD_W   = 15;
    localparam int WEIGHT_W   = 16;
    localparam int CPROD_W    = PERIOD_W + WEIGHT_W;

    localparam logic [PERIOD_W-1:0] NO_MOTION = 15'd32767;
    localparam logic [PERIOD_W-1:0] MAX_MOTION_PERIOD = 15'd32766;

    // poll queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH < 2) ? 1 : $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIR_THRESH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIR_HYST   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PERIOD = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PERIOD = 3'd6;

    typedef struct packed {
        logic [7:0]          center_position;
        logic [7:0]          dead_zone;
        logic [7:0]          direction_threshold;
        logic [7:0]          direction_hysteresis;
        logic [15:0]         filter_alpha;
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] max_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_position:      8'd127,
        dead_zone:            8'd4,
        direction_threshold:  8'd5,
        direction_hysteresis: 8'd5,
        filter_alpha:         16'd5243,
        min_period:           15'd100,
        max_period:           15'd20900
    };

    // one classified poll word
    typedef struct packed {
        logic [7:0] joystick_x;
        logic       z_button;
        logic       c_button;
        logic       stop;
    } poll_t;

    // one result word
    typedef struct packed {
        logic                motor_enable;
        logic                direction_level;
        logic                step_now;
        logic [PERIOD_W-1:0] step_period;
        logic                auto_active;
        logic                has_recording;
        logic                endstop_latched;
    } result_t;

    // normalized exponential weights, Q0.16
    localparam logic [WEIGHT_W-1:0] CURVE_ROM [ROM_ENTRIES] = '{
        16'd65535, 16'd63555, 16'd61633, 16'd59768, 16'd57957,
        16'd56201, 16'd54496, 16'd52841, 16'd51236, 16'd49678,
        16'd48166, 16'd46698, 16'd45274, 16'd43892, 16'd42551,
        16'd41250, 16'd39987, 16'd38761, 16'd37572, 16'd36417,
        16'd35297, 16'd34210, 16'd33155, 16'd32131, 16'd31138,
        16'd30174, 16'd29238, 16'd28330, 16'd27449, 16'd26594,
        16'd25764, 16'd24959, 16'd24177, 16'd23419, 16'd22683,
        16'd21969, 16'd21275, 16'd20603, 16'd19950, 16'd19317,
        16'd18702, 16'd18105, 16'd17526, 16'd16964, 16'd16419,
        16'd15890, 16'd15376, 16'd14878, 16'd14395, 16'd13925,
        16'd13470, 16'd13028, 16'd12599, 16'd12183, 16'd11779,
        16'd11387, 16'd11006, 16'd10637, 16'd10279, 16'd9931,
        16'd9594,  16'd9267,  16'd8949,  16'd8640,  16'd8341,
        16'd8051,  16'd7769,  16'd7496,  16'd7230,  16'd6973,
        16'd6723,  16'd6480,  16'd6245,  16'd6016,  16'd5795,
        16'd5580,  16'd5371,  16'd5168,  16'd4972,  16'd4781,
        16'd4596,  16'd4416,  16'd4241,  16'd4072,  16'd3908,
        16'd3749,  16'd3594,  16'd3444,  16'd3298,  16'd3157,
        16'd3020,  16'd2887,  16'd2757,  16'd2632,  16'd2510,
        16'd2392,  16'd2278,  16'd2167,  16'd2059,  16'd1954,
        16'd1852,  16'd1754,  16'd1658,  16'd1565,  16'd1475,
        16'd1388,  16'd1303,  16'd1220,  16'd1140,  16'd1063,
        16'd988,   16'd914,   16'd844,   16'd775,   16'd708,
        16'd643,   16'd580,   16'd519,   16'd460,   16'd403,
        16'd347,   16'd293,   16'd240,   16'd189,   16'd140,
        16'd92,    16'd45,    16'd0,     16'd0
    };

    function automatic logic [WEIGHT_W-1:0] curve_weight(input logic [CURVE_IDX_W-1:0] idx);
        curve_weight = CURVE_ROM[idx];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/jssc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jssc_front
// accepts poll words, merges the end stops into one stop flag, holds the
// classified word until the queue takes it
// ----------------------------------------------------------------------------
module jssc_front
    import jssc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] joystick_x,
    input  wire logic       z_button,
    input  wire logic       c_button,
    input  wire logic       endstop_low_hit,
    input  wire logic       endstop_high_hit,
    output logic            push_valid,
    input  wire logic       push_ready,
    output poll_t           push_data
);

    logic  hold_valid_reg, hold_valid_next;
    poll_t hold_reg;
    logic  accept;

    assign in_ready   = !hold_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = hold_valid_reg;
    assign push_data  = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg.joystick_x <= joystick_x;
            hold_reg.z_button   <= z_button;
            hold_reg.c_button   <= c_button;
            hold_reg.stop       <= endstop_low_hit | endstop_high_hit;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/jssc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jssc_queue
// short first-in first-out queue of classified poll words
// ----------------------------------------------------------------------------
module jssc_queue
    import jssc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  poll_t     push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output poll_t     pop_data
);

    poll_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/jssc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jssc_back
// carries out one poll: filter, dead zone, direction, speed curve, buttons
// and end-stop lockout, then loads the result register
// ----------------------------------------------------------------------------
module jssc_back
    import jssc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic pop_valid,
    output logic      pop_ready,
    input  poll_t     pop_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   result
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_OFFS  = 4'b0010,
        ST_CURVE = 4'b0100,
        ST_FIN   = 4'b1000
    } back_state_t;

    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_POS  = 2'd1;
    localparam logic [1:0] ROT_NEG  = 2'd2;

    function automatic logic [OFFSET_W-1:0] mag_of(input logic signed [OFFSET_W-1:0] v);
        mag_of = v[OFFSET_W-1] ? OFFSET_W'(-v) : v;
    endfunction

    function automatic logic [1:0] next_rotation(
        input logic signed [OFFSET_W-1:0] off,
        input logic [1:0]                 rot,
        input logic [7:0]                 thr,
        input logic [7:0]                 hys
    );
        logic signed [OFFSET_W-1:0] hys_s;
        logic signed [OFFSET_W-1:0] neg_hys;
        hys_s         = $signed({1'b0, hys});
        neg_hys       = -hys_s;
        next_rotation = rot;
        if (mag_of(off) >= {1'b0, thr})
        begin
            if (off > hys_s && rot != ROT_POS)
            begin
                next_rotation = ROT_POS;
            end
            else if (off < neg_hys && rot != ROT_NEG)
            begin
                next_rotation = ROT_NEG;
            end
        end
    endfunction

    back_state_t state_reg, state_next;

    // per-poll working registers
    poll_t                      item_reg;
    logic signed [PRODA_W-1:0]  prod_a_reg;
    logic signed [PRODB_W-1:0]  prod_b_reg;
    logic signed [ACC_W-1:0]    acc_cand_reg;
    logic signed [OFFSET_W-1:0] off_cand_reg;
    logic [CPROD_W-1:0]         curve_prod_reg;
    logic                       span_neg_reg;

    // controller state
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;
    logic [PERIOD_W-1:0]        period_reg, period_next;
    logic [PERIOD_W-1:0]        saved_period_reg, saved_period_next;
    logic signed [OFFSET_W-1:0] saved_offset_reg, saved_offset_next;
    logic                       auto_reg, auto_next;
    logic                       recorded_reg, recorded_next;
    logic                       lockout_reg, lockout_next;
    logic                       idle_reg, idle_next;
    logic [1:0]                 rotation_reg, rotation_next;
    logic                       z_prev_reg, z_prev_next;
    logic                       c_prev_reg, c_prev_next;

    logic    out_valid_reg, out_valid_next;
    result_t result_reg, result_next;

    logic do_pop, fin_go;

    // pop stage: filter products
    logic signed [OFFSET_W-1:0]   raw;
    logic signed [ALPHA_BITS+1:0] keep_w;
    logic signed [PRODA_W-1:0]    prod_a_next;
    logic signed [PRODB_W-1:0]    prod_b_next;

    // offset stage
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    quo;
    logic signed [ACC_W-1:0]    acc_v;
    logic signed [ACC_W-1:0]    acc_sh;
    logic signed [OFFSET_W-1:0] off_v;

    // curve stage
    logic [OFFSET_W-1:0]    cur_mag;
    logic [CURVE_IDX_W-1:0] curve_idx;
    logic signed [PERIOD_W:0] span;
    logic [PERIOD_W-1:0]    span_mag;
    logic [CPROD_W-1:0]     curve_prod_next;

    // commit stage
    logic [CPROD_W:0]         rounded;
    logic signed [PERIOD_W+1:0] min_s, q_s, p_s;
    logic [PERIOD_W-1:0]      curve_period;
    logic                     step;
    logic [PERIOD_W-1:0]      pulse;

    assign pop_ready = (state_reg == ST_IDLE);
    assign do_pop    = pop_valid && pop_ready;
    assign fin_go    = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (pop_valid) state_next = ST_OFFS;
            ST_OFFS:  state_next = ST_CURVE;
            ST_CURVE: state_next = ST_FIN;
            ST_FIN:   if (fin_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        raw         = $signed({1'b0, pop_data.joystick_x}) - $signed({1'b0, cfg.center_position});
        keep_w      = $signed((ALPHA_BITS + 2)'(1) <<< ALPHA_BITS) -
                      $signed({2'b00, cfg.filter_alpha});
        prod_a_next = $signed({1'b0, cfg.filter_alpha}) * raw;
        prod_b_next = keep_w * acc_reg;
    end

    // acc = sum / 2^16 and offset = acc / 2^F, both toward zero
    always_comb
    begin
        sum = (SUM_W'(prod_a_reg) <<< FILTER_FRACTION_BITS) + SUM_W'(prod_b_reg);
        quo = sum >>> ALPHA_BITS;
        if (sum[SUM_W-1] && (sum[ALPHA_BITS-1:0] != '0))
        begin
            quo = quo + SUM_W'(1);
        end
        acc_v  = quo[ACC_W-1:0];
        acc_sh = acc_v >>> FILTER_FRACTION_BITS;
        if (acc_v[ACC_W-1] && (acc_v[FILTER_FRACTION_BITS-1:0] != '0))
        begin
            acc_sh = acc_sh + ACC_W'(1);
        end
        off_v = acc_sh[OFFSET_W-1:0];
    end

    always_comb
    begin
        cur_mag = mag_of(off_cand_reg);
        if (cur_mag > OFFSET_W'(CURVE_LAST))
        begin
            curve_idx = CURVE_IDX_W'(CURVE_LAST);
        end
        else
        begin
            curve_idx = cur_mag[CURVE_IDX_W-1:0];
        end
        span            = $signed({1'b0, cfg.max_period}) - $signed({1'b0, cfg.min_period});
        span_mag        = span[PERIOD_W] ? PERIOD_W'(-span) : span[PERIOD_W-1:0];
        curve_prod_next = CPROD_W'(span_mag) * CPROD_W'(curve_weight(curve_idx));
    end

    // rounded half away from zero, then clamped to a motion period
    always_comb
    begin
        rounded = {1'b0, curve_prod_reg} + (CPROD_W + 1)'(32'd32768);
        min_s   = $signed({2'b00, cfg.min_period});
        q_s     = $signed({1'b0, rounded[CPROD_W:ALPHA_BITS]});
        p_s     = span_neg_reg ? (min_s - q_s) : (min_s + q_s);
        if (p_s < 0)
        begin
            curve_period = '0;
        end
        else if (p_s > $signed({2'b00, MAX_MOTION_PERIOD}))
        begin
            curve_period = MAX_MOTION_PERIOD;
        end
        else
        begin
            curve_period = p_s[PERIOD_W-1:0];
        end
    end

    always_comb
    begin
        acc_next          = acc_reg;
        offset_next       = offset_reg;
        period_next       = period_reg;
        saved_period_next = saved_period_reg;
        saved_offset_next = saved_offset_reg;
        auto_next         = auto_reg;
        recorded_next     = recorded_reg;
        lockout_next      = lockout_reg;
        idle_next         = idle_reg;
        rotation_next     = rotation_reg;
        z_prev_next       = z_prev_reg;
        c_prev_next       = c_prev_reg;
        step              = 1'b0;

        // end stops first
        if (item_reg.stop)
        begin
            lockout_next = 1'b1;
            idle_next    = 1'b1;
        end
        else if (lockout_next)
        begin
            auto_next    = 1'b0;
            period_next  = NO_MOTION;
            lockout_next = 1'b0;
        end
        pulse = period_next;

        if (!lockout_next)
        begin
            if (!auto_next)
            begin
                acc_next    = acc_cand_reg;
                offset_next = off_cand_reg;
                if (mag_of(offset_next) >= {1'b0, cfg.dead_zone})
                begin
                    idle_next     = 1'b0;
                    rotation_next = next_rotation(offset_next, rotation_next,
                                                  cfg.direction_threshold,
                                                  cfg.direction_hysteresis);
                    period_next   = curve_period;
                end
                else
                begin
                    period_next = NO_MOTION;
                    idle_next   = 1'b1;
                end
            end
            pulse = period_next;
            step  = !idle_next && (period_next != NO_MOTION || offset_next != '0);

            // z edge: record, replay or toggle
            if (item_reg.z_button && !z_prev_next)
            begin
                auto_next = !auto_next;
                if (!(period_next != NO_MOTION || offset_next != '0) && !recorded_next)
                begin
                    auto_next = 1'b0;
                end
                else if (auto_next && !recorded_next)
                begin
                    recorded_next     = 1'b1;
                    saved_period_next = period_next;
                    saved_offset_next = offset_next;
                end
                else if (auto_next && recorded_next)
                begin
                    idle_next     = 1'b0;
                    rotation_next = next_rotation(saved_offset_reg, rotation_next,
                                                  cfg.direction_threshold,
                                                  cfg.direction_hysteresis);
                    period_next   = saved_period_reg;
                end
            end
            z_prev_next = item_reg.z_button;

            // c edge: erase recording
            if (item_reg.c_button && !c_prev_next)
            begin
                recorded_next     = 1'b0;
                auto_next         = 1'b0;
                period_next       = NO_MOTION;
                saved_period_next = '0;
            end
            c_prev_next = item_reg.c_button;
        end

        result_next.motor_enable    = !idle_next;
        result_next.direction_level = (rotation_next == ROT_NEG);
        result_next.step_now        = step;
        result_next.step_period     = pulse;
        result_next.auto_active     = auto_next;
        result_next.has_recording   = recorded_next;
        result_next.endstop_latched = lockout_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            acc_reg          <= '0;
            offset_reg       <= '0;
            period_reg       <= NO_MOTION;
            saved_period_reg <= '0;
            saved_offset_reg <= '0;
            auto_reg         <= 1'b0;
            recorded_reg     <= 1'b0;
            lockout_reg      <= 1'b0;
            idle_reg         <= 1'b1;
            rotation_reg     <= ROT_NONE;
            z_prev_reg       <= 1'b0;
            c_prev_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fin_go)
            begin
                acc_reg          <= acc_next;
                offset_reg       <= offset_next;
                period_reg       <= period_next;
                saved_period_reg <= saved_period_next;
                saved_offset_reg <= saved_offset_next;
                auto_reg         <= auto_next;
                recorded_reg     <= recorded_next;
                lockout_reg      <= lockout_next;
                idle_reg         <= idle_next;
                rotation_reg     <= rotation_next;
                z_prev_reg       <= z_prev_next;
                c_prev_reg       <= c_prev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            item_reg   <= pop_data;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (state_reg == ST_OFFS)
        begin
            acc_cand_reg <= acc_v;
            off_cand_reg <= off_v;
        end
        if (state_reg == ST_CURVE)
        begin
            curve_prod_reg <= curve_prod_next;
            span_neg_reg   <= span[PERIOD_W];
        end
        if (fin_go)
        begin
            result_reg <= result_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/joystick_stepper_speed_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_stepper_speed_controller
// turns joystick polls into stepper enable, direction and step period
// ----------------------------------------------------------------------------
// One input word is one control poll and gives exactly one result word. The
// front takes a poll in any cycle its holding register can move on, folds the
// two end stops into one stop flag and hands it to a two-entry queue. The back
// takes one poll and works it through in order: pop with the two filter
// multiplies, the accumulator and offset update, the speed curve table
// lookup and multiply, and the commit of all controller state into the
// result register. That commit waits only while an earlier result is still
// held on the output, and the back pops no new poll until it has committed.
// Configuration writes are taken at any time (cfg_ready is always high) but
// are meant to land only while no poll is in flight.
// ----------------------------------------------------------------------------
module joystick_stepper_speed_controller
    import jssc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // poll words
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             joystick_x,
    input  wire logic                   z_button,
    input  wire logic                   c_button,
    input  wire logic                   endstop_low_hit,
    input  wire logic                   endstop_high_hit,

    // result words
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        motor_enable,
    output logic                        direction_level,
    output logic                        step_now,
    output logic [PERIOD_W-1:0]         step_period,
    output logic                        auto_active,
    output logic                        has_recording,
    output logic                        endstop_latched,

    // register writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    push_valid, push_ready;
    poll_t   push_data;
    logic    pop_valid, pop_ready;
    poll_t   pop_data;
    result_t result;

    // register file, index order follows the register list
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER:     cfg_next.center_position      = cfg_data[7:0];
                REG_DEAD_ZONE:  cfg_next.dead_zone            = cfg_data[7:0];
                REG_DIR_THRESH: cfg_next.direction_threshold  = cfg_data[7:0];
                REG_DIR_HYST:   cfg_next.direction_hysteresis = cfg_data[7:0];
                REG_ALPHA:      cfg_next.filter_alpha         = cfg_data[15:0];
                REG_MIN_PERIOD: cfg_next.min_period           = cfg_data[PERIOD_W-1:0];
                REG_MAX_PERIOD: cfg_next.max_period           = cfg_data[PERIOD_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and classify
    jssc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .joystick_x       (joystick_x),
        .z_button         (z_button),
        .c_button         (c_button),
        .endstop_low_hit  (endstop_low_hit),
        .endstop_high_hit (endstop_high_hit),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_data        (push_data)
    );

    // decoupling queue
    jssc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: filter, curve, buttons, lockout, result register
    jssc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // result word fan-out
    assign motor_enable    = result.motor_enable;
    assign direction_level = result.direction_level;
    assign step_now        = result.step_now;
    assign step_period     = result.step_period;
    assign auto_active     = result.auto_active;
    assign has_recording   = result.has_recording;
    assign endstop_latched = result.endstop_latched;

endmodule
`default_nettype wire

// ===== tb/joystick_stepper_speed_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_stepper_speed_controller_test
// self-checking bench for the joystick stepper speed controller
// ----------------------------------------------------------------------------
// Polls go in over the poll channel. A behavioral copy of the controller runs
// on every accepted poll and queues the motor command word that should come
// back. Each returned word is compared field by field against the oldest
// queued command. Directed groups cover stick extremes, end-stop lockout and
// recovery, record and replay, and the corner settings. Random phases then
// run stick holds with button and end-stop bursts under several register
// settings. Both sides insert random gaps, with some bursts at full rate.
// ----------------------------------------------------------------------------
module joystick_stepper_speed_controller_test;
    import jssc_pkg::*;

    // run bounds
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int DRAIN_SLACK  = 20;

    // speed curve sizing: last usable curve index
    localparam int CURVE_TOP = 128;
    localparam logic [14:0] STILL_PERIOD = 15'd32767;
    localparam longint PERIOD_CAP = 32766;
    localparam longint FIX_ONE = 64'sd65536;

    // normalized exponential weights, Q0.16
    localparam logic [15:0] SPEED_CURVE [129] = '{
        16'd65535, 16'd63555, 16'd61633, 16'd59768, 16'd57957, 16'd56201, 16'd54496,
        16'd52841, 16'd51236, 16'd49678, 16'd48166, 16'd46698, 16'd45274, 16'd43892,
        16'd42551, 16'd41250, 16'd39987, 16'd38761, 16'd37572, 16'd36417, 16'd35297,
        16'd34210, 16'd33155, 16'd32131, 16'd31138, 16'd30174, 16'd29238, 16'd28330,
        16'd27449, 16'd26594, 16'd25764, 16'd24959, 16'd24177, 16'd23419, 16'd22683,
        16'd21969, 16'd21275, 16'd20603, 16'd19950, 16'd19317, 16'd18702, 16'd18105,
        16'd17526, 16'd16964, 16'd16419, 16'd15890, 16'd15376, 16'd14878, 16'd14395,
        16'd13925, 16'd13470, 16'd13028, 16'd12599, 16'd12183, 16'd11779, 16'd11387,
        16'd11006, 16'd10637, 16'd10279, 16'd9931,  16'd9594,  16'd9267,  16'd8949,
        16'd8640,  16'd8341,  16'd8051,  16'd7769,  16'd7496,  16'd7230,  16'd6973,
        16'd6723,  16'd6480,  16'd6245,  16'd6016,  16'd5795,  16'd5580,  16'd5371,
        16'd5168,  16'd4972,  16'd4781,  16'd4596,  16'd4416,  16'd4241,  16'd4072,
        16'd3908,  16'd3749,  16'd3594,  16'd3444,  16'd3298,  16'd3157,  16'd3020,
        16'd2887,  16'd2757,  16'd2632,  16'd2510,  16'd2392,  16'd2278,  16'd2167,
        16'd2059,  16'd1954,  16'd1852,  16'd1754,  16'd1658,  16'd1565,  16'd1475,
        16'd1388,  16'd1303,  16'd1220,  16'd1140,  16'd1063,  16'd988,   16'd914,
        16'd844,   16'd775,   16'd708,   16'd643,   16'd580,   16'd519,   16'd460,
        16'd403,   16'd347,   16'd293,   16'd240,   16'd189,   16'd140,   16'd92,
        16'd45,    16'd0,     16'd0
    };

    typedef enum logic [1:0] {
        SPIN_UNDECIDED = 2'd0,
        SPIN_POSITIVE  = 2'd1,
        SPIN_NEGATIVE  = 2'd2
    } spin_t;

    // dut ports
    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             joystick_x;
    logic                   z_button;
    logic                   c_button;
    logic                   endstop_low_hit;
    logic                   endstop_high_hit;
    logic                   out_valid;
    logic                   out_ready;
    logic                   motor_enable;
    logic                   direction_level;
    logic                   step_now;
    logic [PERIOD_W-1:0]    step_period;
    logic                   auto_active;
    logic                   has_recording;
    logic                   endstop_latched;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    joystick_stepper_speed_controller dut (.*);

    // controller state mirrored by the bench
    cfg_t        regs_now;
    longint      lp_acc;
    int          stick_off;
    int          offset_saved;
    logic [14:0] period_now;
    logic [14:0] period_saved;
    bit          in_auto;
    bit          have_record;
    bit          locked_out;
    bit          motor_idle;
    spin_t       spin;
    bit          z_last;
    bit          c_last;

    // commands still owed by the dut, oldest first
    result_t     command_queue [$];
    int          failures = 0;

    // flow control knobs: fast means no idle cycles on that side
    bit          tx_fast = 1'b0;
    bit          rx_fast = 1'b0;
    bit          word_taken = 1'b0;
    int          ready_wait = 0;

    // random stick shaping
    logic [7:0]  stick_target = 8'd127;
    int          stick_hold = 0;
    int          stop_burst = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the handshakes hang
    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // behavioral controller
    // ------------------------------------------------------------------------

    function automatic int magnitude_of(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void reset_controller();
        regs_now = '{
            center_position:      8'd127,
            dead_zone:            8'd4,
            direction_threshold:  8'd5,
            direction_hysteresis: 8'd5,
            filter_alpha:         16'd5243,
            min_period:           15'd100,
            max_period:           15'd20900
        };
        lp_acc       = 0;
        stick_off    = 0;
        offset_saved = 0;
        period_now   = STILL_PERIOD;
        period_saved = '0;
        in_auto      = 1'b0;
        have_record  = 1'b0;
        locked_out   = 1'b0;
        motor_idle   = 1'b1;
        spin         = SPIN_UNDECIDED;
        z_last       = 1'b0;
        c_last       = 1'b0;
    endfunction

    // direction rule: small offsets keep the direction, a switch needs the
    // offset beyond the hysteresis band
    function automatic void steer(input int off);
        int thr;
        int hyst;
        thr  = int'(regs_now.direction_threshold);
        hyst = int'(regs_now.direction_hysteresis);
        if (magnitude_of(off) < thr)
            return;
        if (off > hyst && spin != SPIN_POSITIVE)
            spin = SPIN_POSITIVE;
        else if (off < -hyst && spin != SPIN_NEGATIVE)
            spin = SPIN_NEGATIVE;
    endfunction

    // period = min + span * weight, rounded half away from zero; swapped
    // periods give a negative span
    function automatic logic [14:0] curve_period(input int off);
        int     d;
        longint span;
        longint lo;
        longint p;
        d = magnitude_of(off);
        if (d > CURVE_TOP)
            d = CURVE_TOP;
        lo   = longint'(regs_now.min_period);
        span = longint'(regs_now.max_period) - lo;
        if (span >= 0)
            p = lo + (span * longint'(SPEED_CURVE[d]) + 32768) / 65536;
        else
            p = lo - ((-span) * longint'(SPEED_CURVE[d]) + 32768) / 65536;
        if (p > PERIOD_CAP)
            p = PERIOD_CAP;
        if (p < 0)
            p = 0;
        return p[14:0];
    endfunction

    function automatic bit stick_tilted();
        return (period_now != STILL_PERIOD) || (stick_off != 0);
    endfunction

    // one control poll, returns the command word it produces
    function automatic result_t run_poll(input logic [7:0] x, input logic z, input logic c,
                                         input logic lo, input logic hi);
        result_t     word;
        bit          step;
        logic [14:0] pulse;
        longint      raw;
        longint      a;
        step = 1'b0;
        if (lo || hi) begin
            locked_out = 1'b1;
            motor_idle = 1'b1;
        end else if (locked_out) begin
            // first clear poll after a hit: leave auto and stop
            in_auto    = 1'b0;
            period_now = STILL_PERIOD;
            locked_out = 1'b0;
        end
        pulse = period_now;
        if (!locked_out) begin
            if (!in_auto) begin
                raw = longint'(x) - longint'(regs_now.center_position);
                a   = longint'(regs_now.filter_alpha);
                lp_acc    = (a * raw * FIX_ONE + (65536 - a) * lp_acc) / 65536;
                stick_off = int'(lp_acc / FIX_ONE);
                if (magnitude_of(stick_off) >= int'(regs_now.dead_zone)) begin
                    motor_idle = 1'b0;
                    steer(stick_off);
                    period_now = curve_period(stick_off);
                end else begin
                    period_now = STILL_PERIOD;
                    motor_idle = 1'b1;
                end
            end
            pulse = period_now;
            step  = !motor_idle && stick_tilted();

            // z press: record on first use, then toggle or replay
            if (z && !z_last) begin
                in_auto = !in_auto;
                if (!stick_tilted() && !have_record) begin
                    in_auto = 1'b0;
                end else if (in_auto && !have_record) begin
                    have_record  = 1'b1;
                    period_saved = period_now;
                    offset_saved = stick_off;
                end else if (in_auto && have_record) begin
                    motor_idle = 1'b0;
                    steer(offset_saved);
                    period_now = period_saved;
                end
            end
            z_last = z;

            // c press erases the recording
            if (c && !c_last) begin
                have_record  = 1'b0;
                in_auto      = 1'b0;
                period_now   = STILL_PERIOD;
                period_saved = '0;
            end
            c_last = c;
        end

        word.motor_enable    = !motor_idle;
        word.direction_level = (spin == SPIN_NEGATIVE);
        word.step_now        = step;
        word.step_period     = pulse;
        word.auto_active     = in_auto;
        word.has_recording   = have_record;
        word.endstop_latched = locked_out;
        return word;
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    // ready pattern: a fresh stall is drawn after every taken word
    always @(negedge clk) begin
        if (word_taken) begin
            ready_wait = rx_fast ? 0 : $urandom_range(0, 15);
            word_taken = 1'b0;
        end
        if (ready_wait > 0) begin
            out_ready <= 1'b0;
            ready_wait--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && out_ready) begin
            word_taken = 1'b1;
            if (command_queue.size() == 0) begin
                $error("result word with no poll outstanding");
                failures++;
            end else begin
                want = command_queue.pop_front();
                check_field("motor_enable", want.motor_enable, motor_enable);
                check_field("direction_level", want.direction_level, direction_level);
                check_field("step_now", want.step_now, step_now);
                check_field("step_period", want.step_period, step_period);
                check_field("auto_active", want.auto_active, auto_active);
                check_field("has_recording", want.has_recording, has_recording);
                check_field("endstop_latched", want.endstop_latched, endstop_latched);
            end
        end
    end

    // ------------------------------------------------------------------------
    // poll side
    // ------------------------------------------------------------------------

    // one poll word; valid rises after a random gap and holds until taken
    task automatic send_poll(input logic [7:0] x, input logic z, input logic c,
                             input logic lo, input logic hi);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         <= 1'b1;
        joystick_x       <= x;
        z_button         <= z;
        c_button         <= c;
        endstop_low_hit  <= lo;
        endstop_high_hit <= hi;
        do @(posedge clk); while (!in_ready);
        command_queue.push_back(run_poll(x, z, c, lo, hi));
    endtask

    // stop offering polls and wait for every owed command
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (command_queue.size() != 0)
            @(posedge clk);
    endtask

    // register write, only once the pipeline is empty
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_CENTER:     regs_now.center_position      = value[7:0];
            REG_DEAD_ZONE:  regs_now.dead_zone            = value[7:0];
            REG_DIR_THRESH: regs_now.direction_threshold  = value[7:0];
            REG_DIR_HYST:   regs_now.direction_hysteresis = value[7:0];
            REG_ALPHA:      regs_now.filter_alpha         = value;
            REG_MIN_PERIOD: regs_now.min_period           = value[14:0];
            REG_MAX_PERIOD: regs_now.max_period           = value[14:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(input cfg_t r);
        write_reg(REG_CENTER, 16'(r.center_position));
        write_reg(REG_DEAD_ZONE, 16'(r.dead_zone));
        write_reg(REG_DIR_THRESH, 16'(r.direction_threshold));
        write_reg(REG_DIR_HYST, 16'(r.direction_hysteresis));
        write_reg(REG_ALPHA, r.filter_alpha);
        write_reg(REG_MIN_PERIOD, 16'(r.min_period));
        write_reg(REG_MAX_PERIOD, 16'(r.max_period));
    endtask

    // random setting, leaning toward the edges of each range
    function automatic logic [15:0] pick_edge(input int top, input int low_span);
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'(top);
            2:       return 16'($urandom_range(0, low_span));
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    function automatic cfg_t pick_regs();
        cfg_t r;
        r.center_position      = 8'(pick_edge(255, 255));
        r.dead_zone            = 8'(pick_edge(128, 16));
        r.direction_threshold  = 8'(pick_edge(128, 16));
        r.direction_hysteresis = 8'(pick_edge(128, 16));
        // frozen filter only now and then
        case ($urandom_range(0, 7))
            0:       r.filter_alpha = 16'd0;
            1, 2:    r.filter_alpha = 16'hffff;
            3, 4:    r.filter_alpha = 16'($urandom_range(1000, 16000));
            default: r.filter_alpha = 16'($urandom_range(1, 65535));
        endcase
        r.min_period = 15'(pick_edge(32766, 500));
        r.max_period = 15'(pick_edge(32766, 32766));
        return r;
    endfunction

    // stick held on a target for a while, with stray readings, button taps
    // and short end-stop bursts mixed in
    task automatic send_random_poll();
        logic [7:0] x;
        logic       z;
        logic       c;
        logic [1:0] stops;
        if (stick_hold == 0) begin
            case ($urandom_range(0, 5))
                0:       stick_target = 8'd0;
                1:       stick_target = 8'd255;
                2:       stick_target = 8'(regs_now.center_position + $urandom_range(0, 12) - 6);
                default: stick_target = 8'($urandom_range(0, 255));
            endcase
            stick_hold = $urandom_range(1, 40);
        end
        stick_hold--;
        x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : stick_target;
        z = ($urandom_range(0, 7) == 0);
        c = ($urandom_range(0, 24) == 0);
        if (stop_burst == 0 && $urandom_range(0, 59) == 0)
            stop_burst = $urandom_range(1, 4);
        stops = 2'b00;
        if (stop_burst > 0) begin
            stop_burst--;
            stops = 2'($urandom_range(1, 3));
        end
        send_poll(x, z, c, stops[0], stops[1]);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // neutral and full deflection both ways, then the centre at its extremes
    task automatic test_stick_extremes();
        send_poll(8'd127, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_ALPHA, 16'hffff);
        send_poll(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_CENTER, 16'd0);
        send_poll(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_CENTER, 16'd255);
        send_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // hit latches and idles, buttons are ignored while latched, the first
    // clear poll drops the lockout
    task automatic test_endstop_lockout();
        write_reg(REG_CENTER, 16'd127);
        send_poll(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd255, 1'b0, 1'b0, 1'b1, 1'b0);
        send_poll(8'd255, 1'b1, 1'b1, 1'b0, 1'b1);
        send_poll(8'd255, 1'b0, 1'b0, 1'b1, 1'b1);
        send_poll(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // z at rest without a recording, record, toggle off, replay, erase
    task automatic test_record_replay();
        send_poll(8'd127, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(8'd200, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd200, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(8'd50, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd50, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(8'd127, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd127, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(8'd127, 1'b0, 1'b1, 1'b0, 1'b0);
    endtask

    // recording taken inside the dead zone, zero dead zone, swapped periods,
    // a configured period that would read as no motion, direction band edges
    task automatic test_corner_settings();
        write_reg(REG_DEAD_ZONE, 16'd20);
        send_poll(8'd137, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(8'd137, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd137, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(8'd137, 1'b0, 1'b0, 1'b0, 1'b0);
        send_poll(8'd137, 1'b1, 1'b1, 1'b0, 1'b0);
        write_reg(REG_DEAD_ZONE, 16'd0);
        send_poll(8'd127, 1'b0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_MIN_PERIOD, 16'd20000);
        write_reg(REG_MAX_PERIOD, 16'd100);
        send_poll(8'd180, 1'b0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_MIN_PERIOD, 16'd32767);
        write_reg(REG_MAX_PERIOD, 16'd32767);
        send_poll(8'd127, 1'b0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_DIR_THRESH, 16'd0);
        write_reg(REG_DIR_HYST, 16'd0);
        send_poll(8'd126, 1'b0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_DIR_THRESH, 16'd128);
        write_reg(REG_DIR_HYST, 16'd128);
        send_poll(8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // random traffic under the current setting; rates reshuffled in blocks,
    // and once per phase the stream stops until every command is back
    task automatic test_random_traffic(input int polls);
        for (int i = 0; i < polls; i++) begin
            if (i % 50 == 0) begin
                tx_fast = ($urandom_range(0, 3) == 0);
                rx_fast = ($urandom_range(0, 3) == 0);
            end
            if (i == polls / 2)
                wait_drained();
            send_random_poll();
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    task automatic test_random_settings();
        cfg_t defaults;
        defaults = CFG_RESET;
        // keep the live state, only the registers go back to their defaults
        load_regs(defaults);
        test_random_traffic(400);
        repeat (5) begin
            load_regs(pick_regs());
            test_random_traffic(280);
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        joystick_x       = 8'd0;
        z_button         = 1'b0;
        c_button         = 1'b0;
        endstop_low_hit  = 1'b0;
        endstop_high_hit = 1'b0;
        out_ready        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        reset_controller();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_stick_extremes();
        test_endstop_lockout();
        test_record_replay();
        test_corner_settings();
        test_random_settings();

        wait_drained();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/jssc_pkg.sv
rtl/core/jssc_front.sv
rtl/core/jssc_queue.sv
rtl/core/jssc_back.sv
rtl/core/joystick_stepper_speed_controller.sv
tb/joystick_stepper_speed_controller_test.sv
